FILE: hdl/hdat_pkg.sv
// Package with the shared types, codes and constants of the HID descriptor application table.
`default_nettype none

package hdat_pkg;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [6:0] device_address;
        logic [7:0] interface_instance;
        logic       descriptor_last;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [2:0] entry_index;
        logic [7:0] usage_value;
        logic [7:0] usage_page_value;
        logic [7:0] report_id_value;
        logic       table_full;
    } out_item_t;

    typedef struct packed {
        logic [7:0] usage;
        logic [7:0] usage_page;
        logic [6:0] device;
        logic [7:0] iface;
        logic [7:0] report_id;
    } entry_t;

    localparam logic [1:0] MODE_PARSE  = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [2:0] KIND_NONE       = 3'd0;
    localparam logic [2:0] KIND_USAGE_PAGE = 3'd1;
    localparam logic [2:0] KIND_USAGE      = 3'd2;
    localparam logic [2:0] KIND_COLLECTION = 3'd3;
    localparam logic [2:0] KIND_REPORT_ID  = 3'd4;

    localparam logic [7:0] TAG_USAGE_PAGE = 8'h04;
    localparam logic [7:0] TAG_USAGE      = 8'h08;
    localparam logic [7:0] TAG_COLLECTION = 8'ha0;
    localparam logic [7:0] TAG_REPORT_ID  = 8'h84;
    localparam logic [7:0] TAG_MASK       = 8'hfc;
    localparam logic [7:0] SIZE_MASK      = 8'h03;
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

    localparam logic [7:0] COLLECTION_APPLICATION = 8'h01;
    localparam logic [7:0] LIMIT_RESET            = 8'd8;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_CLAIM  = 3'd1;
    localparam logic [2:0] OP_REPORT = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_LOOKUP = 3'd4;

    typedef struct packed {
        logic       load;
        logic       decode;
        logic       scan;
        logic       finish;
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       stop;
    } status_t;

endpackage

`default_nettype wire

FILE: hdl/hdat_table.sv
// Application table storage with one read port, one write port, one valid-bit clear port and per-entry valid bits.
`default_nettype none

module hdat_table #(
    parameter int ENTRIES = 8,
    parameter int IDX_W   = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output hdat_pkg::entry_t       rd_entry,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire hdat_pkg::entry_t  wr_entry,
    input  wire logic              clr_en,
    input  wire logic [IDX_W-1:0]  clr_addr
);

    hdat_pkg::entry_t mem [ENTRIES];
    hdat_pkg::entry_t mem_rd_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               valid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            valid_rd_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[clr_addr] <= 1'b0;
            end
        end
    end

    assign rd_entry = valid_rd_reg ? mem_rd_reg : '0;

endmodule

`default_nettype wire

FILE: hdl/hdat_datapath.sv
// Datapath with the parser registers, item decode, table scan compare and result register.
`default_nettype none

module hdat_datapath #(
    parameter int ENTRIES = 8,
    parameter int IDX_W   = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hdat_pkg::in_item_t  request,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_data,
    input  wire hdat_pkg::cmd_t      cmd,
    output hdat_pkg::status_t        status,
    output hdat_pkg::out_item_t      result
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    hdat_pkg::in_item_t  req_reg;
    hdat_pkg::out_item_t res_reg;
    logic [7:0]       limit_reg;
    logic [2:0]       skip_reg, skip_next;
    logic [2:0]       pending_reg, pending_next;
    logic [7:0]       page_reg, page_next;
    logic [7:0]       usage_reg, usage_next;
    logic [7:0]       value_reg, value_next;
    logic [IDX_W-1:0] cur_reg;
    logic             missing_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] next_idx;
    logic [IDX_W+2:0] scan_idx_ext;

    logic [2:0]       dec_op;
    logic [2:0]       kind;
    logic [1:0]       size_code;
    logic [2:0]       size_bytes;
    logic             apply;
    logic [7:0]       item_value;

    hdat_pkg::entry_t rd_entry;
    hdat_pkg::entry_t wr_entry;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    logic             clr_en;
    logic             last_idx;
    logic             dev_match;
    logic             is_free;
    logic             rid_hit;
    logic             stop;
    logic             claim_ok;
    logic             claim_full;
    logic             lookup_hit;

    function automatic logic [2:0] kind_of_tag(input logic [7:0] tag);
        logic [2:0] k;
        k = hdat_pkg::KIND_NONE;
        case (tag)
            hdat_pkg::TAG_USAGE_PAGE: k = hdat_pkg::KIND_USAGE_PAGE;
            hdat_pkg::TAG_USAGE:      k = hdat_pkg::KIND_USAGE;
            hdat_pkg::TAG_COLLECTION: k = hdat_pkg::KIND_COLLECTION;
            hdat_pkg::TAG_REPORT_ID:  k = hdat_pkg::KIND_REPORT_ID;
            default:                  k = hdat_pkg::KIND_NONE;
        endcase
        return k;
    endfunction

    assign size_code  = 2'(req_reg.data_byte & hdat_pkg::SIZE_MASK);
    assign size_bytes = (size_code == hdat_pkg::SIZE_CODE_FOUR) ? 3'd4 : {1'b0, size_code};

    always_comb
    begin
        dec_op       = hdat_pkg::OP_NONE;
        skip_next    = skip_reg;
        pending_next = pending_reg;
        page_next    = page_reg;
        usage_next   = usage_reg;
        value_next   = value_reg;
        kind         = hdat_pkg::KIND_NONE;
        apply        = 1'b0;
        item_value   = 8'd0;
        case (req_reg.mode)
            hdat_pkg::MODE_PARSE:
            begin
                if (skip_reg != 3'd0)
                begin
                    kind         = pending_reg;
                    item_value   = req_reg.data_byte;
                    apply        = 1'b1;
                    skip_next    = skip_reg - 3'd1;
                    pending_next = hdat_pkg::KIND_NONE;
                end
                else
                begin
                    kind = kind_of_tag(req_reg.data_byte & hdat_pkg::TAG_MASK);
                    if (size_bytes == 3'd0)
                    begin
                        pending_next = hdat_pkg::KIND_NONE;
                        apply        = 1'b1;
                    end
                    else
                    begin
                        skip_next    = size_bytes;
                        pending_next = kind;
                    end
                end
                if (apply)
                begin
                    case (kind)
                        hdat_pkg::KIND_USAGE_PAGE: page_next = item_value;
                        hdat_pkg::KIND_USAGE:
                        begin
                            if (item_value <= limit_reg)
                            begin
                                usage_next = item_value;
                            end
                        end
                        hdat_pkg::KIND_COLLECTION:
                        begin
                            if (item_value == hdat_pkg::COLLECTION_APPLICATION)
                            begin
                                dec_op = hdat_pkg::OP_CLAIM;
                            end
                        end
                        hdat_pkg::KIND_REPORT_ID:
                        begin
                            if (!missing_reg)
                            begin
                                dec_op = hdat_pkg::OP_REPORT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                value_next = item_value;
            end
            hdat_pkg::MODE_REMOVE: dec_op = hdat_pkg::OP_REMOVE;
            hdat_pkg::MODE_LOOKUP: dec_op = hdat_pkg::OP_LOOKUP;
            default:
            begin
            end
        endcase
    end

    assign last_idx     = (scan_idx_reg == LAST_IDX);
    assign next_idx     = last_idx ? '0 : scan_idx_reg + 1'b1;
    assign scan_idx_ext = (IDX_W + 3)'(scan_idx_reg);
    assign dev_match    = (rd_entry.device == req_reg.device_address) &&
                          (rd_entry.iface == req_reg.interface_instance);
    assign is_free      = (rd_entry.usage == 8'd0);
    assign rid_hit      = (rd_entry.report_id == 8'd0) ||
                          (rd_entry.report_id == req_reg.data_byte);

    always_comb
    begin
        wr_en      = 1'b0;
        wr_entry   = rd_entry;
        clr_en     = 1'b0;
        stop       = 1'b0;
        claim_ok   = 1'b0;
        claim_full = 1'b0;
        lookup_hit = 1'b0;
        if (cmd.scan)
        begin
            case (cmd.op)
                hdat_pkg::OP_CLAIM:
                begin
                    if (is_free)
                    begin
                        wr_en               = 1'b1;
                        wr_entry.usage      = usage_reg;
                        wr_entry.usage_page = page_reg;
                        wr_entry.device     = req_reg.device_address;
                        wr_entry.iface      = req_reg.interface_instance;
                        claim_ok            = 1'b1;
                        stop                = 1'b1;
                    end
                    else if (last_idx)
                    begin
                        claim_full = 1'b1;
                        stop       = 1'b1;
                    end
                end
                hdat_pkg::OP_REPORT:
                begin
                    wr_en              = 1'b1;
                    wr_entry.report_id = value_reg;
                    stop               = 1'b1;
                end
                hdat_pkg::OP_REMOVE:
                begin
                    clr_en = dev_match;
                    stop   = last_idx;
                end
                hdat_pkg::OP_LOOKUP:
                begin
                    if (is_free)
                    begin
                        stop = 1'b1;
                    end
                    else if (dev_match && rid_hit)
                    begin
                        lookup_hit = 1'b1;
                        stop       = 1'b1;
                    end
                    else
                    begin
                        stop = last_idx;
                    end
                end
                default: stop = 1'b1;
            endcase
        end
    end

    assign rd_addr = cmd.decode ? ((dec_op == hdat_pkg::OP_REPORT) ? cur_reg : '0) : next_idx;
    assign wr_addr = (cmd.op == hdat_pkg::OP_REPORT) ? cur_reg : scan_idx_reg;

    hdat_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .clr_en   (clr_en),
        .clr_addr (scan_idx_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= hdat_pkg::LIMIT_RESET;
            skip_reg     <= 3'd0;
            pending_reg  <= hdat_pkg::KIND_NONE;
            page_reg     <= 8'd0;
            usage_reg    <= 8'd0;
            cur_reg      <= '0;
            missing_reg  <= 1'b0;
            scan_idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.decode)
            begin
                skip_reg     <= skip_next;
                pending_reg  <= pending_next;
                page_reg     <= page_next;
                usage_reg    <= usage_next;
                scan_idx_reg <= '0;
            end
            else if (cmd.scan && !stop)
            begin
                scan_idx_reg <= next_idx;
            end
            if (claim_ok)
            begin
                cur_reg     <= scan_idx_reg;
                missing_reg <= 1'b0;
            end
            if (claim_full)
            begin
                missing_reg <= 1'b1;
            end
            if (cmd.finish && (req_reg.mode == hdat_pkg::MODE_PARSE) && req_reg.descriptor_last)
            begin
                skip_reg    <= 3'd0;
                pending_reg <= hdat_pkg::KIND_NONE;
                page_reg    <= 8'd0;
                usage_reg   <= 8'd0;
                cur_reg     <= '0;
                missing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.decode)
        begin
            value_reg <= value_next;
            res_reg   <= '0;
        end
        else if (claim_ok)
        begin
            res_reg.entry_index      <= scan_idx_ext[2:0];
            res_reg.usage_value      <= usage_reg;
            res_reg.usage_page_value <= page_reg;
            res_reg.report_id_value  <= rd_entry.report_id;
        end
        else if (claim_full)
        begin
            res_reg.table_full <= 1'b1;
        end
        else if (lookup_hit)
        begin
            res_reg.found            <= 1'b1;
            res_reg.entry_index      <= scan_idx_ext[2:0];
            res_reg.usage_value      <= rd_entry.usage;
            res_reg.usage_page_value <= rd_entry.usage_page;
            res_reg.report_id_value  <= rd_entry.report_id;
        end
    end

    assign status.op   = dec_op;
    assign status.stop = stop;
    assign result      = res_reg;

endmodule

`default_nettype wire

FILE: hdl/hdat_ctrl.sv
// Controller state machine that sequences decode, table scan and result transfer.
`default_nettype none

module hdat_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output hdat_pkg::cmd_t         cmd,
    input  wire hdat_pkg::status_t status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                op_next    = status.op;
                state_next = (status.op == hdat_pkg::OP_NONE) ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                if (status.stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= hdat_pkg::OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.decode = (state_reg == S_DECODE);
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.finish = (state_reg == S_DONE);
    assign cmd.op     = op_reg;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after the result transfer");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.decode, cmd.scan, cmd.finish}))
        else $error("more than one datapath command at once");

    a_scan_op: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> cmd.op != hdat_pkg::OP_NONE)
        else $error("table scan without a table operation");
`endif

endmodule

`default_nettype wire

FILE: hdl/hid_descriptor_application_table_unit.sv
// Top level of the HID descriptor application table: controller, datapath and config port.
// A descriptor byte with no table access gives its result without a table scan, a Report ID
// write updates the claimed entry, and a claim, remove or lookup scans up to TABLE_ENTRIES
// entries, one entry per cycle through one read port.
// One item is in work at a time; the next start is taken the cycle after the done strobe.
// Reset clears the parser state and all table valid bits at once and sets the limit to 8.
`default_nettype none

module hid_descriptor_application_table_unit #(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire hdat_pkg::in_item_t  request,
    output logic                     done,
    output hdat_pkg::out_item_t      result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    hdat_pkg::cmd_t    cmd;
    hdat_pkg::status_t status;

    assign cfg_ready = 1'b1;

    hdat_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    hdat_datapath #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

endmodule

`default_nettype wire
